// ===== hw/rtl/dqaqm_pkg.sv =====
`default_nettype none
package dqaqm_pkg;

  localparam int unsigned HandleW  = 16;
  localparam int unsigned LenW     = 11;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned EntryW   = HandleW + LenW + TimeW;
  localparam int unsigned ByteW    = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [16:0] ProbOne  = 17'h10000;

  typedef enum logic [2:0] {
    EV_QUEUED   = 3'd0,
    EV_TAILDROP = 3'd1,
    EV_SENT     = 3'd2,
    EV_MARKED   = 3'd3,
    EV_AQMDROP  = 3'd4,
    EV_EMPTY    = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    CFG_COUNT_BYTES = 3'd0,
    CFG_QUEUE_LIMIT = 3'd1,
    CFG_CSCALE      = 3'd2,
    CFG_LOFFSET     = 3'd3,
    CFG_CURVY       = 3'd4,
    CFG_MARK_THR    = 3'd5,
    CFG_EWMA_SHIFT  = 3'd6,
    CFG_RNG_SEED    = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DRAW,
    ST_DECIDE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [0:0]        action;
    logic [TimeW-1:0]  now_time;
    logic [LenW-1:0]   pkt_len;
    logic [0:0]        is_l4s;
    logic [HandleW-1:0] pkt_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [HandleW-1:0] out_handle;
    logic [0:0]         from_l4s;
    logic [0:0]         last;
  } out_item_t;

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  // delay scaled by 2^-shift, saturated to one
  function automatic logic [16:0] scaled_prob(input logic [31:0] v, input logic signed [6:0] sh);
    logic [47:0] p;
    logic [5:0]  n;
    p = '0;
    if (!sh[6]) begin
      p = (sh >= 7'sd32) ? 48'd0 : {16'd0, v >> sh[4:0]};
    end else begin
      n = 6'(-sh);
      p = (n > 6'd16) ? ((v != 32'd0) ? {31'd0, ProbOne} : 48'd0) : ({16'd0, v} << n[4:0]);
    end
    return (p > {31'd0, ProbOne}) ? ProbOne : p[16:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dqaqm_if.sv =====
`default_nettype none
interface dqaqm_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dqaqm_ram.sv =====
`default_nettype none
module dqaqm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/dual_queue_coupled_aqm_core.sv =====
`default_nettype none
// channel  dir  payload
// in_ch    in   action, now_time, pkt_len, is_l4s, pkt_handle
// out_ch   out  event_res, out_handle, from_l4s, last
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
// enqueue and empty dequeue: read, evaluate and output states; the next input
// waits until the result has left.
// dequeue: read, evaluate, a draw state that repeats for each random draw, decide
// and output (no draws on a backlog mark, curviness draws for l4s, 2*curviness
// for classic); a classic drop run restarts at the read per packet.
// reset clears counts, pointers, average and loads the seed; no clearing pass.
// a stalled output blocks new input and the next step of a drop run.
module dual_queue_coupled_aqm_core #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dqaqm_if.sink     in_ch,
  dqaqm_if.source   out_ch,
  input  wire logic                          cfg_we_i,
  input  wire logic [dqaqm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dqaqm_pkg::CfgDataW-1:0] cfg_data_i
);
  import dqaqm_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  // configuration registers
  logic        cnt_bytes_q;
  logic [16:0] limit_q, thr_q;
  logic [5:0]  cscale_q;
  logic [3:0]  loff_q, eshift_q;
  logic [2:0]  curvy_q;
  logic [31:0] rng_q, rng_d;

  state_e      state_q, state_d;
  in_item_t    item_q;
  logic [AW-1:0] chead_q, ctail_q, lhead_q, ltail_q;
  logic [CW-1:0] cpkts_q, lpkts_q;
  logic [ByteW-1:0] cbytes_q, lbytes_q;
  logic [31:0] avg_q, avg_d;
  logic [16:0] prob_q, maxd_q;
  logic [3:0]  draws_q;
  logic        mark_q;
  out_item_t   res_q;
  logic        ovalid_q;

  logic [EntryW-1:0] crd, lrd;
  logic cwe, lwe;
  logic [EntryW-1:0] wentry;
  logic [AW-1:0] cra, lra;

  assign wentry = {item_q.pkt_handle, item_q.pkt_len, item_q.now_time};
  assign cra = chead_q;
  assign lra = lhead_q;

  dqaqm_ram #(.Width(EntryW), .Depth(FIFO_DEPTH)) u_cram (
    .clk_i, .we_i(cwe), .waddr_i(ctail_q), .wdata_i(wentry),
    .raddr_i(cra), .rdata_o(crd));
  dqaqm_ram #(.Width(EntryW), .Depth(FIFO_DEPTH)) u_lram (
    .clk_i, .we_i(lwe), .waddr_i(ltail_q), .wdata_i(wentry),
    .raddr_i(lra), .rdata_o(lrd));

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
    return (32'(i) + 32'd1 >= FIFO_DEPTH) ? '0 : AW'(32'(i) + 32'd1);
  endfunction

  logic enq_drop;
  logic [31:0] cdelay;
  logic [31:0] ldiff;
  logic signed [6:0] lshift, cshift;
  logic [31:0] x1;
  logic [ByteW-1:0] lrem;

  always_comb begin
    enq_drop = cnt_bytes_q ?
      ((19'(cbytes_q) + 19'(lbytes_q) + 19'(item_q.pkt_len)) > 19'(limit_q)) :
      ((18'(cpkts_q) + 18'(lpkts_q)) >= 18'(limit_q));
    if ((item_q.is_l4s ? 32'(lpkts_q) : 32'(cpkts_q)) >= FIFO_DEPTH) enq_drop = 1'b1;
    cdelay = item_q.now_time - crd[TimeW-1:0];
    cshift = 7'sd4 + 7'(signed'(cscale_q));
    lshift = cshift + 7'(signed'({1'b0, loff_q}));
    ldiff = (cdelay >= avg_q) ? ((cdelay - avg_q) >> eshift_q) : ((avg_q - cdelay) >> eshift_q);
    avg_d = (cdelay >= avg_q) ? avg_q + ldiff : avg_q - ldiff;
    x1 = xorshift(rng_q);
    lrem = lbytes_q - ByteW'(lrd[TimeW +: LenW]);
  end

  // control sequencer
  always_comb begin
    state_d = state_q;
    cwe = 1'b0;
    lwe = 1'b0;
    unique case (state_q)
      ST_IDLE:   if (in_ch.valid && !ovalid_q) state_d = ST_READ;
      // wait for the previous result of a drop run to leave
      ST_READ:   if (!ovalid_q) state_d = ST_EVAL;
      ST_EVAL:   state_d = (item_q.action == 1'b0 || (lpkts_q == '0 && cpkts_q == '0))
                   ? ST_OUT : ST_DRAW;
      ST_DRAW:   if (draws_q == '0) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_OUT;
      // drop run continues on the next head
      ST_OUT:    if (!ovalid_q || out_ch.ready) state_d = res_q.last ? ST_IDLE : ST_READ;
      default:   state_d = ST_IDLE;
    endcase
    if (state_q == ST_EVAL && item_q.action == 1'b0 && !enq_drop) begin
      cwe = !item_q.is_l4s;
      lwe = item_q.is_l4s;
    end
  end

  logic serve_l4s_q;
  logic [EntryW-1:0] ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_bytes_q <= 1'b0; limit_q <= 17'd25; cscale_q <= 6'h3F; loff_q <= 4'd1;
      curvy_q <= 3'd1; thr_q <= 17'd7500; eshift_q <= 4'd5; rng_q <= 32'd1;
      chead_q <= '0; ctail_q <= '0; lhead_q <= '0; ltail_q <= '0;
      cpkts_q <= '0; lpkts_q <= '0; cbytes_q <= '0; lbytes_q <= '0;
      avg_q <= '0; ovalid_q <= 1'b0; draws_q <= '0; mark_q <= 1'b0;
      serve_l4s_q <= 1'b0; prob_q <= '0; maxd_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT) ovalid_q <= 1'b1;
      else if (out_ch.ready) ovalid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_COUNT_BYTES: cnt_bytes_q <= cfg_data_i[0];
          CFG_QUEUE_LIMIT: limit_q <= cfg_data_i[16:0];
          CFG_CSCALE:      cscale_q <= cfg_data_i[5:0];
          CFG_LOFFSET:     loff_q <= cfg_data_i[3:0];
          CFG_CURVY:       curvy_q <= cfg_data_i[2:0];
          CFG_MARK_THR:    thr_q <= cfg_data_i[16:0];
          CFG_EWMA_SHIFT:  eshift_q <= cfg_data_i[3:0];
          CFG_RNG_SEED:    rng_q <= (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_EVAL: begin
          mark_q <= (item_q.action == 1'b1) && (lpkts_q != '0) && (lrem > thr_q);
          maxd_q <= '0;
          if (item_q.action == 1'b0) begin
            res_q <= '{enq_drop ? EV_TAILDROP : EV_QUEUED, item_q.pkt_handle,
                       item_q.is_l4s, 1'b1};
            if (!enq_drop && item_q.is_l4s) begin
              ltail_q <= nxt(ltail_q); lpkts_q <= lpkts_q + 1'b1;
              lbytes_q <= lbytes_q + ByteW'(item_q.pkt_len);
            end else if (!enq_drop) begin
              ctail_q <= nxt(ctail_q); cpkts_q <= cpkts_q + 1'b1;
              cbytes_q <= cbytes_q + ByteW'(item_q.pkt_len);
            end
          end else if (lpkts_q != '0) begin
            serve_l4s_q <= 1'b1;
            ent_q <= lrd;
            lhead_q <= nxt(lhead_q); lpkts_q <= lpkts_q - 1'b1;
            lbytes_q <= lrem;
            prob_q <= scaled_prob((cpkts_q != '0) ? cdelay : 32'd0, lshift);
            draws_q <= (lrem > thr_q) ? 4'd0 : 4'(curvy_q);
          end else if (cpkts_q == '0) begin
            res_q <= '{EV_EMPTY, '0, 1'b0, 1'b1};
          end else begin
            serve_l4s_q <= 1'b0;
            ent_q <= crd;
            chead_q <= nxt(chead_q); cpkts_q <= cpkts_q - 1'b1;
            cbytes_q <= cbytes_q - ByteW'(crd[TimeW +: LenW]);
            avg_q <= avg_d;
            prob_q <= scaled_prob(avg_d, cshift);
            draws_q <= {curvy_q, 1'b0};
          end
        end
        ST_DRAW: if (draws_q != '0) begin
          rng_q <= x1;
          draws_q <= draws_q - 1'b1;
          if ({1'b0, x1[31:16]} > maxd_q) maxd_q <= {1'b0, x1[31:16]};
        end
        ST_DECIDE: begin
          if (serve_l4s_q) begin
            res_q <= '{(mark_q || prob_q > maxd_q) ? EV_MARKED : EV_SENT,
                       ent_q[EntryW-1 -: HandleW], 1'b1, 1'b1};
          end else if (prob_q > maxd_q) begin
            res_q <= '{EV_AQMDROP, ent_q[EntryW-1 -: HandleW], 1'b0, cpkts_q == '0};
          end else begin
            res_q <= '{EV_SENT, ent_q[EntryW-1 -: HandleW], 1'b0, 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_ch.valid && !ovalid_q) item_q <= in_ch.data;
  end

  assign in_ch.ready  = (state_q == ST_IDLE) && !ovalid_q;
  assign out_ch.valid = ovalid_q;
  assign out_ch.data  = res_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cpkts_q) <= FIFO_DEPTH && 32'(lpkts_q) <= FIFO_DEPTH) else $error("count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_empty_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cpkts_q == '0) |-> (cbytes_q == '0)) else $error("byte count stale");
  a_seed_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rng_q != 32'd0) else $error("rng zero");
`endif
endmodule
`default_nettype wire
